[hw/rtl/assert_macros.svh]
// Assertion helpers used by the bound checker in hw/rtl/mpq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define CHK_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[hw/rtl/mpq_pkg.sv]
package mpq_pkg;

   localparam int Capacity  = 64;
   localparam int AddrWidth = $clog2(Capacity);
   localparam int CntWidth  = AddrWidth + 1;

   localparam int TagWidth   = 32;
   localparam int IdWidth    = 16;
   localparam int ScoreWidth = 10;
   localparam int KindWidth  = 2;

   localparam logic [KindWidth-1:0] KIND_INSERT = 2'd0;
   localparam logic [KindWidth-1:0] KIND_PEEK   = 2'd1;
   localparam logic [KindWidth-1:0] KIND_POP    = 2'd2;
   localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [TagWidth-1:0]   tag;
      logic [IdWidth-1:0]    id;
      logic [ScoreWidth-1:0] score;
   } rec_type;

   // Rank key: larger score first, then smaller id.
   function automatic logic [ScoreWidth+IdWidth-1:0] rank_key(input rec_type r);
      rank_key = {r.score, ~r.id};
   endfunction

endpackage

[hw/rtl/max_priority_queue_with_tiebreak_core.sv]
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | kind, name_tag, record_id, score
// rsp      | out       | rsp_valid/rsp_stall  | empty_res, dropped, top_tag, top_id, top_score
//
// Records sit sorted in a circular buffer memory (one write, one registered read port).
// A peek, an empty pop and a full insert (dropped) go straight to the response state; a pop
// that leaves records first reads the new head. An insert loops read-compare-shift over the
// memory port, moving one record toward the tail per pass, which sets the insert time.
// Synchronous active-high reset empties the queue at once.
// A stalled result holds in the output register; the next request is still taken and
// waits in its response state until the register frees.
module max_priority_queue_with_tiebreak_core
   import mpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KindWidth-1:0]  req_kind,
   input  logic [TagWidth-1:0]   req_name_tag,
   input  logic [IdWidth-1:0]    req_record_id,
   input  logic [ScoreWidth-1:0] req_score,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_empty_res,
   output logic                  rsp_dropped,
   output logic [TagWidth-1:0]   rsp_top_tag,
   output logic [IdWidth-1:0]    rsp_top_id,
   output logic [ScoreWidth-1:0] rsp_top_score
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_POPRD = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   rec_type mem [Capacity];

   logic [2:0]           state_ff, state_in;
   logic [AddrWidth-1:0] head_ff, head_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [CntWidth-1:0]  idx_ff, idx_in;
   rec_type              rec_ff, rec_in;
   rec_type              top_ff, top_in;
   logic                 drop_ff, drop_in;
   rec_type              rdata_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_drop_ff, rsp_drop_in;
   rec_type              rsp_rec_ff, rsp_rec_in;

   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   rec_type              wr_data;
   logic                 accept;
   rec_type              req_rec;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_rec   = '{tag: req_name_tag, id: req_record_id, score: req_score};

   // Sequence the operation and drive the memory port.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rec_in       = rec_ff;
      top_in       = top_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_empty_in = rsp_empty_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_rec_in   = rsp_rec_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = rec_ff;
      rd_addr      = head_ff + AddrWidth'(1);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               drop_in  = 1'b0;
               rec_in   = req_rec;
               state_in = ST_RESP;
               if (req_kind == KIND_INSERT) begin
                  if (count_ff == CntWidth'(Capacity)) begin
                     drop_in = 1'b1;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_READ;
                  end
               end else if (req_kind == KIND_POP && count_ff != '0) begin
                  head_in  = head_ff + AddrWidth'(1);
                  count_in = count_ff - CntWidth'(1);
                  if (count_ff > CntWidth'(1)) begin
                     state_in = ST_POPRD;
                  end
               end
            end
         end
         ST_READ: begin
            // Place at the head, or fetch the neighbor toward the head.
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = head_ff;
               wr_data  = rec_ff;
               top_in   = rec_ff;
               count_in = count_ff + CntWidth'(1);
               state_in = ST_RESP;
            end else begin
               rd_addr  = head_ff + idx_ff[AddrWidth-1:0] - AddrWidth'(1);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = head_ff + idx_ff[AddrWidth-1:0];
            if (rank_key(rdata_ff) >= rank_key(rec_ff)) begin
               wr_data  = rec_ff;
               count_in = count_ff + CntWidth'(1);
               state_in = ST_RESP;
            end else begin
               wr_data  = rdata_ff;
               idx_in   = idx_ff - CntWidth'(1);
               state_in = ST_READ;
            end
         end
         ST_POPRD: begin
            top_in   = rdata_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = (count_ff == '0);
               rsp_drop_in  = drop_ff;
               rsp_rec_in   = (count_ff == '0) ? '0 : top_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Write and read the record store.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Advance control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rec_ff       <= rec_in;
      top_ff       <= top_in;
      drop_ff      <= drop_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_dropped   = rsp_drop_ff;
   assign rsp_top_tag   = rsp_rec_ff.tag;
   assign rsp_top_id    = rsp_rec_ff.id;
   assign rsp_top_score = rsp_rec_ff.score;

endmodule

[hw/rtl/mpq_checker.sv]
`include "assert_macros.svh"

module mpq_props
   import mpq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_empty_res,
   input logic                  rsp_dropped,
   input logic [TagWidth-1:0]   rsp_top_tag,
   input logic [IdWidth-1:0]    rsp_top_id,
   input logic [ScoreWidth-1:0] rsp_top_score
);

   // Hold a stalled result.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_top_id) && $stable(rsp_top_tag), "stalled result changed")
   // Empty results carry a cleared record.
   `CHK_ALWAYS(a_empty_zero, clock, reset, !(rsp_valid && rsp_empty_res) || (rsp_top_tag == '0 && rsp_top_id == '0 && rsp_top_score == '0), "empty result has a record")
   // A dropped insert means the queue was full.
   `CHK_ALWAYS(a_drop_full, clock, reset, !(rsp_valid && rsp_dropped) || !rsp_empty_res, "drop reported on empty queue")

endmodule

bind max_priority_queue_with_tiebreak_core mpq_props u_mpq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_empty_res (rsp_empty_res),
   .rsp_dropped   (rsp_dropped),
   .rsp_top_tag   (rsp_top_tag),
   .rsp_top_id    (rsp_top_id),
   .rsp_top_score (rsp_top_score)
);

[dv/mpq_checker.sv]
module mpq_checker
   import mpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [KindWidth-1:0]  req_kind,
   input  logic [TagWidth-1:0]   req_name_tag,
   input  logic [IdWidth-1:0]    req_record_id,
   input  logic [ScoreWidth-1:0] req_score,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_empty_res,
   input  logic                  rsp_dropped,
   input  logic [TagWidth-1:0]   rsp_top_tag,
   input  logic [IdWidth-1:0]    rsp_top_id,
   input  logic [ScoreWidth-1:0] rsp_top_score,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic                  empty_res;
      logic                  dropped;
      logic [TagWidth-1:0]   tag;
      logic [IdWidth-1:0]    id;
      logic [ScoreWidth-1:0] score;
   } top_report_type;

   rec_type        sorted_recs[$];
   top_report_type expected_tops[$];

   assign pending_count = expected_tops.size();

   // Apply one request to the sorted shadow queue and return the top report.
   function automatic top_report_type apply_request(input logic [KindWidth-1:0] kind,
                                                    input rec_type r);
      top_report_type rep;
      int          pos;
      logic [ScoreWidth+IdWidth-1:0] new_key;
      logic [ScoreWidth+IdWidth-1:0] cur_key;
      rep = '0;
      if (kind == KIND_INSERT) begin
         if (sorted_recs.size() >= Capacity) begin
            rep.dropped = 1'b1;
         end else begin
            new_key = {r.score, ~r.id};
            pos = 0;
            // equal rank goes behind existing records
            while (pos < sorted_recs.size()) begin
               cur_key = {sorted_recs[pos].score, ~sorted_recs[pos].id};
               if (cur_key < new_key) break;
               pos++;
            end
            sorted_recs.insert(pos, r);
         end
      end else if (kind == KIND_POP) begin
         if (sorted_recs.size() > 0) void'(sorted_recs.pop_front());
      end
      if (sorted_recs.size() == 0) begin
         rep.empty_res = 1'b1;
      end else begin
         rep.tag   = sorted_recs[0].tag;
         rep.id    = sorted_recs[0].id;
         rep.score = sorted_recs[0].score;
      end
      return rep;
   endfunction

   // Predict on accepted requests, compare accepted results in order.
   always @(posedge clock) begin
      top_report_type exp_rep;
      rec_type        r;
      if (reset) begin
         sorted_recs.delete();
         expected_tops.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tops.size() == 0) begin
               $error("unexpected result");
               fail_count <= fail_count + 1;
            end else begin
               exp_rep = expected_tops.pop_front();
               if (rsp_empty_res !== exp_rep.empty_res || rsp_dropped !== exp_rep.dropped ||
                   rsp_top_tag !== exp_rep.tag || rsp_top_id !== exp_rep.id ||
                   rsp_top_score !== exp_rep.score)
                  fail_count <= fail_count + 1;
               if (rsp_empty_res !== exp_rep.empty_res)
                  $error("empty_res exp %0h got %0h", exp_rep.empty_res, rsp_empty_res);
               if (rsp_dropped !== exp_rep.dropped)
                  $error("dropped exp %0h got %0h", exp_rep.dropped, rsp_dropped);
               if (rsp_top_tag !== exp_rep.tag)
                  $error("top_tag exp %0h got %0h", exp_rep.tag, rsp_top_tag);
               if (rsp_top_id !== exp_rep.id)
                  $error("top_id exp %0h got %0h", exp_rep.id, rsp_top_id);
               if (rsp_top_score !== exp_rep.score)
                  $error("top_score exp %0h got %0h", exp_rep.score, rsp_top_score);
            end
         end
         if (req_valid && !req_stall) begin
            r.tag   = req_name_tag;
            r.id    = req_record_id;
            r.score = req_score;
            expected_tops.push_back(apply_request(req_kind, r));
         end
      end
   end

endmodule

[dv/tb_top.sv]
module tb_top;
   import mpq_pkg::*;

   localparam int IdleLimit = 20000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KindWidth-1:0]  req_kind = KIND_PEEK;
   logic [TagWidth-1:0]   req_name_tag = '0;
   logic [IdWidth-1:0]    req_record_id = '0;
   logic [ScoreWidth-1:0] req_score = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_empty_res;
   logic                  rsp_dropped;
   logic [TagWidth-1:0]   rsp_top_tag;
   logic [IdWidth-1:0]    rsp_top_id;
   logic [ScoreWidth-1:0] rsp_top_score;
   int                    fail_count;
   int                    pending_count;
   bit                    hold_rsp = 1'b0;
   bit                    stim_done = 1'b0;
   int                    idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   max_priority_queue_with_tiebreak_core i_dut (.*);

   mpq_checker i_checker (.*);

   // Draw a gap length: mostly short, sometimes long.
   function automatic int gap_len();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request and hold it until accepted.
   task automatic send_request(input logic [KindWidth-1:0] kind, input logic [TagWidth-1:0] tag,
                               input logic [IdWidth-1:0] id, input logic [ScoreWidth-1:0] score);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_name_tag  <= tag;
      req_record_id <= id;
      req_score     <= score;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_gap(input bit use_gap);
      int n;
      n = use_gap ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Random record with a narrow score/id range to force ties now and then.
   task automatic send_random(input bit use_gap, input int ins_pct, input int pop_pct);
      int               sel;
      logic [KindWidth-1:0] kind;
      sel = $urandom_range(0, 99);
      if (sel < ins_pct) kind = KIND_INSERT;
      else if (sel < ins_pct + pop_pct) kind = KIND_POP;
      else if (sel < 98) kind = KIND_PEEK;
      else kind = KIND_UNUSED;
      if ($urandom_range(0, 1))
         send_request(kind, $urandom, IdWidth'($urandom_range(0, 7)),
                      ScoreWidth'($urandom_range(0, 7)));
      else
         send_request(kind, $urandom, IdWidth'($urandom), ScoreWidth'($urandom));
      send_gap(use_gap);
   endtask

   // Receiver stall: random gaps, or a long hold-off while requested.
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 99) < 8) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 99) < 2) rsp_stall <= ($urandom_range(0, 1) == 1);
      else rsp_stall <= (gap_len() > 0) && !stim_done;
   end

   // Watchdog: end the run after too many cycles with no handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int i;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty peek, empty pop, unused kind, field extremes
      send_request(KIND_PEEK, '0, '0, '0);
      send_request(KIND_POP, '1, '1, '1);
      send_request(KIND_UNUSED, '0, '0, '0);
      send_request(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
      send_request(KIND_INSERT, 32'h0, 16'h0, 10'h0);
      send_request(KIND_INSERT, 32'h1111_1111, 16'h0, 10'h3FF);
      send_request(KIND_INSERT, 32'h2222_2222, 16'h0, 10'h3FF);
      send_request(KIND_INSERT, 32'h3333_3333, 16'h5, 10'h200);
      send_request(KIND_PEEK, '0, '0, '0);
      for (i = 0; i < 6; i++) send_request(KIND_POP, '0, '0, '0);

      // Fill past capacity to see dropped inserts, then empty again
      for (i = 0; i < Capacity + 3; i++)
         send_request(KIND_INSERT, $urandom, IdWidth'($urandom_range(0, 3)),
                      ScoreWidth'($urandom_range(0, 3)));
      for (i = 0; i < Capacity + 1; i++) send_request(KIND_POP, '0, '0, '0);

      // Back pressure: hold the receiver while requests keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (i = 0; i < 20; i++) send_random(1'b0, 70, 15);
      join
      drain();

      // Random phases with different insert/pop mixes
      for (i = 0; i < 1800; i++) begin
         if (i % 300 == 0) drain();
         case ((i / 300) % 3)
            0: send_random(1'b1, 45, 35);
            1: send_random(1'b1, 75, 15);
            default: send_random(i % 2 == 0, 30, 55);
         endcase
      end
      drain();
      stim_done = 1'b1;
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
